@@ src/seismic_sample_to_double_defines.svh @@
// Assertion macros used by the checker file.
// No dependencies.
`ifndef SEISMIC_SAMPLE_TO_DOUBLE_DEFINES_SVH
`define SEISMIC_SAMPLE_TO_DOUBLE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define SSD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// Delayed implication, checked outside reset.
`define SSD_ASSERT_LATER(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) else $error(msg);
`endif

@@ src/ssd_pkg.sv @@
// Package for the seismic sample converter: format codes and types.
// No dependencies.
package ssd_pkg;
  localparam logic [4:0] FMT_IBM = 5'd1;
  localparam logic [4:0] FMT_I32 = 5'd2;
  localparam logic [4:0] FMT_I16 = 5'd3;
  localparam logic [4:0] FMT_F32 = 5'd5;
  localparam logic [4:0] FMT_F64 = 5'd6;
  localparam logic [4:0] FMT_I24 = 5'd7;
  localparam logic [4:0] FMT_I8  = 5'd8;
  localparam logic [4:0] FMT_I64 = 5'd9;
  localparam logic [4:0] FMT_U32 = 5'd10;
  localparam logic [4:0] FMT_U16 = 5'd11;
  localparam logic [4:0] FMT_U64 = 5'd12;
  localparam logic [4:0] FMT_U24 = 5'd15;
  localparam logic [4:0] FMT_U8  = 5'd16;
  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_ENDIAN = 1'b1;
  typedef struct packed {
    logic [4:0] sample_format;
    logic       file_little_endian;
  } cfg_t;
endpackage

@@ src/ssd_if.sv @@
// Channel interfaces: a valid/ready stream and the register write port.
// Depends on nothing.
interface ssd_stream_if #(parameter int W = 64);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface ssd_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] double_bits;
  logic        format_error;
  modport source(output valid, output double_bits, output format_error, input ready);
  modport sink(input valid, input double_bits, input format_error, output ready);
endinterface

interface ssd_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [4:0]  wdata;
  modport source(output valid, output index, output wdata, input ready);
  modport sink(input valid, input index, input wdata, output ready);
endinterface

@@ src/ssd_convert.sv @@
// Combinational conversion of one raw sample word to a binary64 pattern.
// Depends on ssd_pkg.
module ssd_convert
  import ssd_pkg::*;
(
  input  cfg_t        cfg,
  input  logic [63:0] raw_sample,
  output logic [63:0] double_bits,
  output logic        format_error
);
  logic [63:0] g8;
  logic [31:0] g4;
  logic [23:0] g3;
  logic [15:0] g2;
  logic [7:0]  g1;
  logic [63:0] ival;
  logic        isgn;
  logic        is_int;
  logic [63:0] mag;
  logic [5:0]  p;
  logic [63:0] norm;
  logic [52:0] mant;
  logic        rnd;
  logic [53:0] mant_r;
  logic [10:0] iexp;
  logic [63:0] int_res;
  logic [63:0] ibm_res;
  logic [63:0] f32_res;
  logic [4:0]  ip;
  logic [4:0]  fp;
  logic [10:0] ibm_e;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      g8[8*i +: 8] = cfg.file_little_endian ? raw_sample[8*i +: 8] : raw_sample[8*(7-i) +: 8];
    end
    for (int i = 0; i < 4; i++) begin
      g4[8*i +: 8] = cfg.file_little_endian ? raw_sample[8*i +: 8] : raw_sample[8*(3-i) +: 8];
    end
    for (int i = 0; i < 3; i++) begin
      g3[8*i +: 8] = cfg.file_little_endian ? raw_sample[8*i +: 8] : raw_sample[8*(2-i) +: 8];
    end
    g2 = cfg.file_little_endian ? raw_sample[15:0] : {raw_sample[7:0], raw_sample[15:8]};
    g1 = raw_sample[7:0];
  end

  // Integer path: pick operand, take magnitude, normalize, round.
  always_comb begin
    is_int = 1'b1;
    ival = '0;
    isgn = 1'b0;
    unique case (cfg.sample_format)
      FMT_I32: begin ival = {{32{g4[31]}}, g4}; isgn = g4[31]; end
      FMT_I16: begin ival = {{48{g2[15]}}, g2}; isgn = g2[15]; end
      FMT_I24: begin ival = {{40{g3[23]}}, g3}; isgn = g3[23]; end
      FMT_I8:  begin ival = {{56{g1[7]}}, g1}; isgn = g1[7]; end
      FMT_I64: begin ival = g8; isgn = g8[63]; end
      FMT_U32: ival = {32'd0, g4};
      FMT_U16: ival = {48'd0, g2};
      FMT_U64: ival = g8;
      FMT_U24: ival = {40'd0, g3};
      FMT_U8:  ival = {56'd0, g1};
      default: is_int = 1'b0;
    endcase
    mag = isgn ? (64'd0 - ival) : ival;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (mag[i]) p = 6'(i);
    end
    norm = mag << (6'd63 - p);
    mant = norm[63:11];
    rnd = norm[10] && ((|norm[9:0]) || norm[11]);
    mant_r = {1'b0, mant} + 54'(rnd);
    iexp = 11'(p) + 11'd1023 + 11'(mant_r[53]);
    int_res = (mag == 64'd0) ? 64'd0
      : {isgn, iexp, mant_r[53] ? mant_r[52:1] : mant_r[51:0]};
  end

  // IBM and single: leading-one search over 24 bits (IBM) and 23 bits (single).
  always_comb begin
    ip = '0;
    fp = '0;
    for (int i = 0; i < 24; i++) begin
      if (g4[i]) ip = 5'(i);
      if (i < 23 && g4[i]) fp = 5'(i);
    end
    ibm_e = 11'(ip) + {2'b0, g4[30:24], 2'b0} + 11'd743;
    // Shift the leading one up to bit 52, where the truncation drops it.
    ibm_res = (g4[23:0] == 24'd0) ? {g4[31], 63'd0}
      : {g4[31], ibm_e, 52'({g4[23:0], 29'd0} << (5'd23 - ip))};
    if (g4[30:23] == 8'hff) begin
      f32_res = (g4[22:0] == 23'd0) ? {g4[31], 11'h7ff, 52'd0}
        : {g4[31], 11'h7ff, 1'b1, g4[21:0], 29'd0};
    end else if (g4[30:23] == 8'h00) begin
      f32_res = (g4[22:0] == 23'd0) ? {g4[31], 63'd0}
        : {g4[31], 11'(fp) + 11'd874, 52'({g4[22:0], 29'd0} << (5'd23 - fp))};
    end else begin
      f32_res = {g4[31], 11'(g4[30:23]) + 11'd896, g4[22:0], 29'd0};
    end
  end

  always_comb begin
    format_error = 1'b0;
    if (cfg.sample_format == FMT_IBM) double_bits = ibm_res;
    else if (cfg.sample_format == FMT_F32) double_bits = f32_res;
    else if (cfg.sample_format == FMT_F64) double_bits = g8;
    else if (is_int) double_bits = int_res;
    else begin
      double_bits = '0;
      format_error = 1'b1;
    end
  end
endmodule

@@ src/seismic_sample_to_double.sv @@
// Seismic sample converter: one raw sample word per transfer becomes one
// IEEE binary64 pattern. Depends on ssd_pkg, ssd_if and ssd_convert.
// Each accepted word is converted by the logic between the input register and
// the result register, so one sample is taken every cycle while the result
// buffer has room; a result passes the input register, then the result buffer,
// and a two-entry result buffer lets the input keep flowing while a result waits.
// Write the two registers (format code, byte order) only while idle.
module seismic_sample_to_double
  import ssd_pkg::*;
(
  input logic clk,
  input logic rst,
  ssd_stream_if.sink   in_ch,
  ssd_result_if.source out_ch,
  ssd_cfg_if.sink      cfg_ch
);
  cfg_t        cfg;
  logic        in_valid;
  logic [63:0] in_word;
  logic [63:0] conv_bits;
  logic        conv_err;
  logic [63:0] q_bits [2];
  logic        q_err [2];
  logic [1:0]  q_cnt;
  logic        q_rd;
  logic        q_wr;
  logic        push;
  logic        pop;

  assign cfg_ch.ready = 1'b1;

  // Hold the configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_format <= FMT_IBM;
      cfg.file_little_endian <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_FORMAT: cfg.sample_format <= cfg_ch.wdata;
        REG_ENDIAN: cfg.file_little_endian <= cfg_ch.wdata[0];
        default: ;
      endcase
    end
  end

  // Accept while the buffer can absorb what is in flight: after this edge
  // at most one entry may be held, so the new word still finds room.
  assign in_ch.ready = (q_cnt == 2'd0) || (q_cnt == 2'd1 && (!in_valid || pop))
                    || (q_cnt == 2'd2 && pop && !in_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_ch.valid && in_ch.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_word <= in_ch.data;
  end

  ssd_convert u_conv (
    .cfg(cfg), .raw_sample(in_word), .double_bits(conv_bits), .format_error(conv_err)
  );

  assign push = in_valid;
  assign pop = out_ch.valid && out_ch.ready;
  assign out_ch.valid = q_cnt != 2'd0;
  assign out_ch.double_bits = q_bits[q_rd];
  assign out_ch.format_error = q_err[q_rd];

  // Advance the result buffer pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
      q_rd <= 1'b0;
      q_wr <= 1'b0;
    end else begin
      if (push) q_wr <= ~q_wr;
      if (pop) q_rd <= ~q_rd;
      q_cnt <= q_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_bits[q_wr] <= conv_bits;
      q_err[q_wr] <= conv_err;
    end
  end
endmodule

@@ src/ssd_checker.sv @@
// Port-level checker for the seismic sample converter, bound to the top.
// Depends on the defines header and the top level's ports.
`include "seismic_sample_to_double_defines.svh"
module ssd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_bits,
  input logic        out_err
);
  `SSD_ASSERT_IMPL(a_err_zero, clk, rst, out_valid && out_err, out_bits == 64'd0, "error result not zero")
  `SSD_ASSERT_LATER(a_result_follows, clk, rst, in_valid && in_ready, out_valid, "no result after transfer")
  `SSD_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_bits), "stalled result changed")
endmodule

bind seismic_sample_to_double ssd_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_bits(out_ch.double_bits), .out_err(out_ch.format_error)
);
